>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers used by the radix-to-ASCII converter top level.
// Define ASSERT_OFF to compile all checks out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> src/u2a_pkg.sv
// ----------------------------------------------------------------------------
// u2a_pkg
// Shared types, constants and helper functions of the radix-to-ASCII converter.
// ----------------------------------------------------------------------------
`default_nettype none

package u2a_pkg;

    localparam int          DIGIT_DEPTH_DEF = 32;
    localparam int          QUEUE_DEPTH     = 2;
    localparam logic [5:0]  RADIX_MIN       = 6'd2;
    localparam logic [5:0]  RADIX_MAX       = 6'd36;
    localparam logic [5:0]  DIGIT_MAX       = 6'd35;
    localparam logic [5:0]  DECIMAL_DIGITS  = 6'd10;
    localparam logic [6:0]  CHAR_ZERO       = 7'h30;   // '0'
    localparam logic [6:0]  CHAR_ALPHA_BASE = 7'h57;   // 'a' - 10

    // One conversion request
    typedef struct packed {
        logic [31:0] value;
        logic [5:0]  radix;
    } u2a_item_t;

    // Front to queue
    typedef struct packed {
        logic      push;
        u2a_item_t item;
    } u2a_push_t;

    // Queue head to back
    typedef struct packed {
        logic      valid;
        u2a_item_t item;
    } u2a_head_t;

    // Result of one byte of long division
    typedef struct packed {
        logic [7:0] quo;
        logic [5:0] rem;
    } u2a_div_t;

    // Saturate the raw radix field into 2..36
    function automatic logic [5:0] clamp_radix(input logic [5:0] raw);
        logic [5:0] r;
        r = raw;
        if (r < RADIX_MIN) r = RADIX_MIN;
        if (r > RADIX_MAX) r = RADIX_MAX;
        return r;
    endfunction

    // Index of the highest nonzero byte, zero for an all-zero word
    function automatic logic [1:0] top_byte(input logic [31:0] w);
        logic [1:0] idx;
        if (w[31:24] != 8'd0)      idx = 2'd3;
        else if (w[23:16] != 8'd0) idx = 2'd2;
        else if (w[15:8] != 8'd0)  idx = 2'd1;
        else                       idx = 2'd0;
        return idx;
    endfunction

    // Eight restoring-division steps: partial remainder stays below the radix
    function automatic u2a_div_t div_byte(input logic [5:0] rem_in,
                                          input logic [7:0] byte_in,
                                          input logic [5:0] radix);
        u2a_div_t   res;
        logic [6:0] r;
        r       = {1'b0, rem_in};
        res.quo = 8'd0;
        for (int i = 7; i >= 0; i--) begin
            r = {r[5:0], byte_in[i]};
            if (r >= {1'b0, radix}) begin
                r          = r - {1'b0, radix};
                res.quo[i] = 1'b1;
            end
        end
        res.rem = r[5:0];
        return res;
    endfunction

    // Digit value to ASCII: 0-9 then a-z
    function automatic logic [6:0] glyph(input logic [5:0] d);
        logic [5:0] dc;
        logic [6:0] c;
        dc = (d > DIGIT_MAX) ? DIGIT_MAX : d;
        if (dc < DECIMAL_DIGITS) c = CHAR_ZERO + {1'b0, dc};
        else                     c = CHAR_ALPHA_BASE + {1'b0, dc};
        return c;
    endfunction

endpackage

`default_nettype wire

>>> src/unsigned_to_base_n_ascii.sv
// Sequence: a request is registered into the request queue; the engine pops it,
//   then for each digit divides the current quotient byte by byte from its
//   highest nonzero byte down to byte zero, primes readout, then sends one digit
//   per cycle out while the output is not stalled.
// Throughput: one value per conversion; the next request queues meanwhile.
// Reset: asynchronous, active low; clears control state, not the digit store.
// ----------------------------------------------------------------------------
// unsigned_to_base_n_ascii
// Converts a 32-bit unsigned value to ASCII digits in radix 2..36, most
// significant digit first, tlast on the final digit.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module unsigned_to_base_n_ascii #(
    parameter int DIGIT_DEPTH = u2a_pkg::DIGIT_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // [31:0] value, [37:32] radix
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [6:0] digit_char
    output logic             m_axis_tlast
);

    u2a_pkg::u2a_push_t q_push;
    u2a_pkg::u2a_head_t q_head;
    logic               q_full;
    logic               q_pop;

    u2a_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .q_full        (q_full),
        .q_push        (q_push)
    );

    u2a_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_push (q_push),
        .q_full (q_full),
        .q_head (q_head),
        .q_pop  (q_pop)
    );

    u2a_back #(
        .DIGIT_DEPTH (DIGIT_DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Output characters are only digits or lower-case letters
    `ASSERT_IMPLIES(a_char_range, clk, rst_n, m_axis_tvalid, (m_axis_tdata >= 8'h30 && m_axis_tdata <= 8'h39) || (m_axis_tdata >= 8'h61 && m_axis_tdata <= 8'h7a))

    // Engine never pops an empty queue
    `ASSERT_IMPLIES(a_pop_nonempty, clk, rst_n, q_pop, q_head.valid)

    // Front never pushes into a full queue
    `ASSERT_IMPLIES(a_no_push_full, clk, rst_n, q_full, !q_push.push)

    // A pop with no push frees a slot
    `ASSERT_NEXT(a_pop_frees, clk, rst_n, q_full && q_pop && !q_push.push, !q_full)

endmodule

`default_nettype wire

>>> src/u2a_front.sv
// ----------------------------------------------------------------------------
// u2a_front
// Input side: takes requests from the stream, saturates the radix and
// pushes them into the request queue.
// ----------------------------------------------------------------------------
`default_nettype none

module u2a_front (
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [39:0]         s_axis_tdata,   // [31:0] value, [37:32] radix
    input  wire logic                q_full,
    output u2a_pkg::u2a_push_t       q_push
);

    // Ready whenever the queue has room
    assign s_axis_tready = !q_full;

    // Saturate the radix and push
    always_comb
    begin
        q_push.push       = s_axis_tvalid && !q_full;
        q_push.item.value = s_axis_tdata[31:0];
        q_push.item.radix = u2a_pkg::clamp_radix(s_axis_tdata[37:32]);
    end

endmodule

`default_nettype wire

>>> src/u2a_queue.sv
// ----------------------------------------------------------------------------
// u2a_queue
// Short request queue between the front and the conversion engine.
// ----------------------------------------------------------------------------
`default_nettype none

module u2a_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire u2a_pkg::u2a_push_t q_push,
    output logic                    q_full,
    output u2a_pkg::u2a_head_t      q_head,
    input  wire logic               q_pop
);

    localparam int PW = $clog2(u2a_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(u2a_pkg::QUEUE_DEPTH + 1);

    u2a_pkg::u2a_item_t entry_reg [u2a_pkg::QUEUE_DEPTH];
    logic [PW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]      count_reg, count_next;
    logic               do_push, do_pop;

    assign q_full      = (count_reg == CW'(u2a_pkg::QUEUE_DEPTH));
    assign q_head.valid = (count_reg != '0);
    assign q_head.item  = entry_reg[rd_ptr_reg];

    assign do_push = q_push.push && !q_full;
    assign do_pop  = q_pop && q_head.valid;

    // Pointer and count update with wraparound
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(u2a_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(u2a_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= q_push.item;
        end
    end

endmodule

`default_nettype wire

>>> src/u2a_back.sv
// ----------------------------------------------------------------------------
// u2a_back
// Conversion engine: byte-serial division by the radix into the digit
// store, then readout most significant digit first into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module u2a_back #(
    parameter int DIGIT_DEPTH = u2a_pkg::DIGIT_DEPTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire u2a_pkg::u2a_head_t q_head,
    output logic                    q_pop,
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [7:0]              m_axis_tdata,   // [6:0] digit_char
    output logic                    m_axis_tlast
);

    localparam int AW = $clog2(DIGIT_DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_PREP,
        ST_EMIT
    } state_t;

    state_t            state_reg, state_next;
    logic [31:0]       quo_reg, quo_next;
    logic [5:0]        radix_reg, radix_next;
    logic [5:0]        rem_reg, rem_next;
    logic [1:0]        byte_idx_reg, byte_idx_next;
    logic [AW-1:0]     wr_idx_reg, wr_idx_next;
    logic [AW-1:0]     rd_idx_reg, rd_idx_next;
    logic              out_valid_reg, out_valid_next;
    logic [6:0]        out_char_reg, out_char_next;
    logic              out_last_reg, out_last_next;

    logic [5:0]        digit_mem [DIGIT_DEPTH];
    logic [5:0]        rd_data_reg;

    u2a_pkg::u2a_div_t step;
    logic [31:0]       quo_step;
    logic              wr_en;
    logic              out_free;

    // One byte of long division per cycle
    always_comb
    begin
        step     = u2a_pkg::div_byte(rem_reg, quo_reg[{byte_idx_reg, 3'b000} +: 8], radix_reg);
        quo_step = quo_reg;
        quo_step[{byte_idx_reg, 3'b000} +: 8] = step.quo;
    end

    assign wr_en    = (state_reg == ST_DIV) && (byte_idx_reg == 2'd0);
    assign out_free = !out_valid_reg || m_axis_tready;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        quo_next       = quo_reg;
        radix_next     = radix_reg;
        rem_next       = rem_reg;
        byte_idx_next  = byte_idx_reg;
        wr_idx_next    = wr_idx_reg;
        rd_idx_next    = rd_idx_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        q_pop          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_head.valid) begin
                    q_pop         = 1'b1;
                    quo_next      = q_head.item.value;
                    radix_next    = q_head.item.radix;
                    rem_next      = '0;
                    byte_idx_next = u2a_pkg::top_byte(q_head.item.value);
                    wr_idx_next   = '0;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                quo_next = quo_step;
                if (byte_idx_reg != 2'd0) begin
                    byte_idx_next = byte_idx_reg - 1'b1;
                    rem_next      = step.rem;
                end else if (quo_step == 32'd0 || wr_idx_reg == AW'(DIGIT_DEPTH - 1)) begin
                    // last digit written this cycle
                    rd_idx_next = wr_idx_reg;
                    state_next  = ST_PREP;
                end else begin
                    wr_idx_next   = wr_idx_reg + 1'b1;
                    rem_next      = '0;
                    byte_idx_next = u2a_pkg::top_byte(quo_step);
                end
            end
            ST_PREP:
            begin
                // store read of the top digit lands this cycle
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_char_next  = u2a_pkg::glyph(rd_data_reg);
                    out_last_next  = (rd_idx_reg == '0);
                    if (rd_idx_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        rd_idx_next = rd_idx_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            quo_reg       <= '0;
            radix_reg     <= u2a_pkg::RADIX_MIN;
            rem_reg       <= '0;
            byte_idx_reg  <= '0;
            wr_idx_reg    <= '0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_char_reg  <= u2a_pkg::CHAR_ZERO;
            out_last_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            quo_reg       <= quo_next;
            radix_reg     <= radix_next;
            rem_reg       <= rem_next;
            byte_idx_reg  <= byte_idx_next;
            wr_idx_reg    <= wr_idx_next;
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= out_valid_next;
            out_char_reg  <= out_char_next;
            out_last_reg  <= out_last_next;
        end
    end

    // Digit store: one write port, registered read at the next read index
    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            digit_mem[wr_idx_reg] <= step.rem;
        end
        rd_data_reg <= digit_mem[rd_idx_next];
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_char_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

>>> dv/u2a_digit_checker.sv
// ----------------------------------------------------------------------------
// u2a_digit_checker
// Watches both stream channels of the radix-to-ASCII converter. Every accepted
// request is expanded into the digit characters it must produce. Each emitted
// digit is compared, char and tlast, against the oldest one still pending.
// ----------------------------------------------------------------------------
`default_nettype none

module u2a_digit_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // [31:0] value, [37:32] radix
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [7:0]  m_axis_tdata,   // [6:0] digit_char
    input  wire logic        m_axis_tlast,
    output int               mismatches,
    output int               digits_pending
);

    localparam logic [6:0] CHAR_LOWER_A = 7'h61;   // 'a'
    localparam int         MAX_DIGITS   = 32;
    localparam int         REPORT_LIMIT = 10;

    typedef struct packed {
        logic [6:0] digit_char;
        logic       last;
    } digit_exp_t;

    digit_exp_t expected_digits[$];

    initial
    begin
        mismatches     = 0;
        digits_pending = 0;
    end

    // Divide down by the saturated radix, then queue digits most significant first
    function automatic void queue_digits(input logic [31:0] value,
                                         input logic [5:0] radix_raw);
        logic [5:0]  base;
        logic [31:0] quot;
        logic [5:0]  rems [MAX_DIGITS];
        int          count;
        digit_exp_t  e;
        base = radix_raw;
        if (base < u2a_pkg::RADIX_MIN) base = u2a_pkg::RADIX_MIN;
        if (base > u2a_pkg::RADIX_MAX) base = u2a_pkg::RADIX_MAX;
        quot  = value;
        count = 0;
        do
        begin
            rems[count] = 6'(quot % {26'd0, base});
            quot        = quot / {26'd0, base};
            count++;
        end
        while (quot != 32'd0 && count < MAX_DIGITS);
        for (int i = count - 1; i >= 0; i--)
        begin
            if (rems[i] < 6'd10)
                e.digit_char = u2a_pkg::CHAR_ZERO + {1'b0, rems[i]};
            else
                e.digit_char = CHAR_LOWER_A + {1'b0, rems[i]} - 7'd10;
            e.last = (i == 0);
            expected_digits.push_back(e);
        end
    endfunction

    // Predict on each accepted request, compare on each accepted digit
    always @(posedge clk)
    begin
        digit_exp_t want;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                queue_digits(s_axis_tdata[31:0], s_axis_tdata[37:32]);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_digits.size() == 0)
                begin
                    if (mismatches < REPORT_LIMIT)
                        $display("unexpected digit: char=%h last=%b",
                                 m_axis_tdata[6:0], m_axis_tlast);
                    mismatches++;
                end
                else
                begin
                    want = expected_digits.pop_front();
                    if (m_axis_tdata[6:0] !== want.digit_char
                        || m_axis_tlast !== want.last)
                    begin
                        if (mismatches < REPORT_LIMIT)
                            $display("digit mismatch: exp char=%h last=%b, got char=%h last=%b",
                                     want.digit_char, want.last,
                                     m_axis_tdata[6:0], m_axis_tlast);
                        mismatches++;
                    end
                end
            end
            digits_pending <= expected_digits.size();
        end
    end

endmodule

`default_nettype wire

>>> dv/tb_unsigned_to_base_n_ascii.sv
// ----------------------------------------------------------------------------
// tb_unsigned_to_base_n_ascii
// Drives conversion requests into the radix-to-ASCII converter: a directed
// set of corner values and radices, then random requests with random gaps on
// the request side and random back-pressure on the digit side, including one
// long hold-off. The checker beside the block predicts and compares digits.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_unsigned_to_base_n_ascii;

    localparam int RANDOM_REQUESTS = 388;
    localparam int HOLD_CYCLES     = 400;
    localparam int DRAIN_CYCLES    = 200;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = 40'd0;   // [31:0] value, [37:32] radix
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;           // [6:0] digit_char
    logic        m_axis_tlast;

    int          mismatches;
    int          digits_pending;

    // Shared idling controls: sender sets bursty and hold_req, receiver follows and sets hold_done
    bit          bursty = 1'b1;
    bit          hold_req = 1'b0;
    bit          hold_done = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    unsigned_to_base_n_ascii uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    u2a_digit_checker digit_chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tlast   (m_axis_tlast),
        .mismatches     (mismatches),
        .digits_pending (digits_pending)
    );

    // Offer one request from a falling edge, return at the falling edge after accept
    task automatic offer_request(input logic [31:0] value, input logic [5:0] radix);
        if (bursty && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, radix, value};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        @(negedge clk);
    endtask

    // Random value: full width, small, or a random bit length
    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        case ($urandom_range(0, 3))
            0:       v = $urandom_range(0, 40);
            1:       v = $urandom() >> $urandom_range(0, 31);
            default: v = $urandom();
        endcase
        return v;
    endfunction

    // Mostly legal radices, some from the whole 6-bit field
    function automatic logic [5:0] pick_radix();
        logic [5:0] r;
        if ($urandom_range(0, 4) == 0)
            r = 6'($urandom_range(0, 63));
        else
            r = 6'($urandom_range(u2a_pkg::RADIX_MIN, u2a_pkg::RADIX_MAX));
        return r;
    endfunction

    // Digit-side ready: random runs and stalls, one long hold-off
    initial
    begin
        @(negedge clk);
        while (!rst_n) @(negedge clk);
        forever
        begin
            if (hold_req && !hold_done)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            else if (bursty && $urandom_range(0, 2) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(negedge clk);
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: zero, extremes, saturated radices, digit boundaries
        offer_request(32'd0, 6'd10);
        offer_request(32'd0, 6'd0);
        offer_request(32'd0, 6'd63);
        offer_request(32'hFFFF_FFFF, 6'd2);
        offer_request(32'hFFFF_FFFF, 6'd36);
        offer_request(32'hFFFF_FFFF, 6'd63);
        offer_request(32'hFFFF_FFFF, 6'd0);
        offer_request(32'd1, 6'd1);
        offer_request(32'd1, 6'd2);
        offer_request(32'd35, 6'd36);
        offer_request(32'd36, 6'd36);
        offer_request(32'd9, 6'd10);
        offer_request(32'd10, 6'd16);
        offer_request(32'd255, 6'd16);
        offer_request(32'h8000_0000, 6'd2);
        offer_request(32'd12345, 6'd37);
        offer_request(32'h1234_5678, 6'd8);
        offer_request(32'hAAAA_AAAA, 6'd3);
        offer_request(32'h5555_5555, 6'd5);
        offer_request(32'hDEAD_BEEF, 6'd17);
        offer_request(32'd4294967295, 6'd35);
        offer_request(32'd46655, 6'd36);

        // Random requests; a quiet stretch mid-run and at the end
        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            if (i == 30)
                hold_req = 1'b1;
            bursty = !((i >= 200 && i < 260) || i >= RANDOM_REQUESTS - 50);
            offer_request(pick_value(), pick_radix());
        end
        s_axis_tvalid <= 1'b0;

        while (digits_pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0 && digits_pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog
    initial
    begin
        #4000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
